[design/omc_pkg.sv]
// shared constants and types for the orthogonal matrix check
`default_nettype none
package omc_pkg;
  localparam int unsigned MAX_SIZE_DEF    = 16;
  localparam int unsigned ENTRY_WIDTH_DEF = 16;
  localparam int unsigned IN_WIDTH        = 16;
  localparam int unsigned SIZE_WIDTH      = 5;
  localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 5'd4;

  // per-cell control for one step of the dot product pass
  typedef struct packed {
    logic shift;   // rotate row shift lines by one column
    logic clear;   // start a new dot product
    logic accum;   // add product of current heads
  } cell_ctl_t;
endpackage
`default_nettype wire

[design/orthogonal_matrix_check.sv]
// top level of the orthogonal matrix check
`default_nettype none
// Entries come in row-major order, one per request while busy is low; each
// enters the shift line of its row cell. Every row line holds MAX_SIZE
// columns. After the n real entries of a row, busy stays high while zeros
// fill the unused tail columns, so the full rotation adds nothing beyond the
// real columns. The entry that completes an n x n matrix starts the check,
// after that row's zero fill. For each probe row j the row lines rotate
// through all MAX_SIZE columns (a full rotation restores order), every cell
// forming its dot product with row j in parallel. A drain step then adds the
// last registered product and a compare step checks the sums. From the last
// entry, busy stays high through the zero fill and all n probe rows; the
// verdict is shown on out_valid for the one cycle in which busy drops and
// cannot be held off by the receiver.
module orthogonal_matrix_check #(
  parameter int unsigned MAX_SIZE    = omc_pkg::MAX_SIZE_DEF,
  parameter int unsigned ENTRY_WIDTH = omc_pkg::ENTRY_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire [omc_pkg::IN_WIDTH-1:0]       in_entry_value,
  output logic                              out_valid,
  output logic                              out_is_orthogonal,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [omc_pkg::SIZE_WIDTH-1:0]     cfg_data
);
  import omc_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_SIZE);
  localparam int unsigned CW  = $clog2(MAX_SIZE + 1);
  localparam int unsigned AW  = 2 * ENTRY_WIDTH + CW + 1;
  localparam int unsigned SW  = $clog2(MAX_SIZE + 4);
  localparam logic [1:0] ST_LOAD = 2'd0, ST_FILL = 2'd1, ST_SCAN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [SIZE_WIDTH-1:0] size_r;
  logic [CW-1:0] n;
  logic [CW-1:0] row_r, col_r, probe_r;
  logic [SW-1:0] step_r;
  logic          ok_r, out_v_r, out_b_r;

  // clamp the configured size
  always_comb begin
    if (size_r == '0) n = CW'(1);
    else if (32'(size_r) > MAX_SIZE) n = CW'(MAX_SIZE);
    else n = CW'(size_r);
  end

  wire take = start && !busy;
  wire fill = (state_r == ST_FILL);
  wire cfg_wr = cfg_valid && cfg_ready;
  wire signed [ENTRY_WIDTH-1:0] ev = in_entry_value[ENTRY_WIDTH-1:0];
  wire signed [ENTRY_WIDTH-1:0] ld_val = fill ? '0 : ev;
  wire last_col = (col_r == n - CW'(1));
  wire last_row = (row_r == n - CW'(1));
  wire chk = (state_r == ST_SCAN) && (32'(step_r) == MAX_SIZE + 1);
  wire last_probe = (probe_r == n - CW'(1));
  // accumulators start clean on entry to the check and after every compare
  wire clr = (state_r != ST_SCAN) || chk;

  cell_ctl_t ctl;
  logic signed [ENTRY_WIDTH-1:0] heads [MAX_SIZE];
  logic signed [AW-1:0] accs [MAX_SIZE];
  logic signed [ENTRY_WIDTH-1:0] probe_v;
  assign probe_v = heads[probe_r[IW-1:0]];

  always_comb begin
    ctl.shift = (state_r == ST_SCAN) && (32'(step_r) < MAX_SIZE);
    ctl.accum = ctl.shift;
    ctl.clear = clr;
  end

  // row cells
  for (genvar g = 0; g < MAX_SIZE; g++) begin : g_cell
    omc_cell #(.MAX_SIZE(MAX_SIZE), .ENTRY_WIDTH(ENTRY_WIDTH), .ACC_WIDTH(AW)) u_cell (
      .clk(clk),
      .load_en((take || fill) && row_r == CW'(g)),
      .load_value(ld_val),
      .ctl(ctl),
      .probe(probe_v),
      .head(heads[g]),
      .acc(accs[g])
    );
  end

  // verdict check of all rows against the probe row once drained
  logic all_ok;
  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < MAX_SIZE; i++) begin
      if (CW'(i) < n) begin
        if (accs[i] != ((CW'(i) == probe_r) ? AW'(1) : AW'(0))) all_ok = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      state_nxt = ST_LOAD;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (take && last_col) begin
            if (32'(n) < MAX_SIZE) state_nxt = ST_FILL;
            else if (last_row) state_nxt = ST_SCAN;
            else state_nxt = ST_LOAD;
          end
        end
        ST_FILL: begin
          if (32'(col_r) == MAX_SIZE - 1) state_nxt = last_row ? ST_SCAN : ST_LOAD;
        end
        ST_SCAN: begin
          if (chk && last_probe) state_nxt = ST_LOAD;
        end
        default: state_nxt = ST_LOAD;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; size_r <= SIZE_RESET;
      row_r <= '0; col_r <= '0; probe_r <= '0; step_r <= '0;
      ok_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        size_r <= cfg_data; row_r <= '0; col_r <= '0;
      end else if (take || fill) begin
        if (state_nxt == ST_SCAN) begin
          row_r <= '0; col_r <= '0; probe_r <= '0; step_r <= '0; ok_r <= 1'b1;
        end else if ((fill && 32'(col_r) == MAX_SIZE - 1) ||
                     (!fill && last_col && state_nxt == ST_LOAD)) begin
          row_r <= row_r + CW'(1); col_r <= '0;
        end else begin
          col_r <= col_r + CW'(1);
        end
      end else if (state_r == ST_SCAN) begin
        if (chk) begin
          step_r <= '0;
          ok_r <= ok_r && all_ok;
          if (last_probe) begin
            probe_r <= '0;
          end else begin
            probe_r <= probe_r + CW'(1);
          end
        end else begin
          step_r <= step_r + SW'(1);
        end
      end
    end
  end

  // verdict register, one cycle pulse after the last compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0; out_b_r <= 1'b0;
    end else if (chk && last_probe) begin
      out_v_r <= 1'b1; out_b_r <= ok_r && all_ok;
    end else begin
      out_v_r <= 1'b0;
    end
  end

  assign busy = (state_r != ST_LOAD);
  assign cfg_ready = (state_r == ST_LOAD);
  assign out_valid = out_v_r;
  assign out_is_orthogonal = out_b_r;

  // verdict only ever comes out of the check pass
  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_SCAN) else $error("verdict outside check");
  // no input accepted while scanning
  a_no_take_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !take) else $error("entry taken during check");
  // load position stays inside the matrix
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> row_r < n) else $error("row out of range");
endmodule
`default_nettype wire

[design/omc_cell.sv]
// one matrix row: shift line of entries plus a row-times-row accumulator
`default_nettype none
module omc_cell #(
  parameter int unsigned MAX_SIZE    = omc_pkg::MAX_SIZE_DEF,
  parameter int unsigned ENTRY_WIDTH = omc_pkg::ENTRY_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH   = 2 * ENTRY_WIDTH + 7
) (
  input  wire                           clk,
  input  wire                           load_en,
  input  wire signed [ENTRY_WIDTH-1:0]  load_value,
  input  wire omc_pkg::cell_ctl_t       ctl,
  input  wire signed [ENTRY_WIDTH-1:0]  probe,
  output logic signed [ENTRY_WIDTH-1:0] head,
  output logic signed [ACC_WIDTH-1:0]   acc
);
  import omc_pkg::*;

  logic signed [ENTRY_WIDTH-1:0] line_r [MAX_SIZE];
  logic signed [2*ENTRY_WIDTH-1:0] prod_r;
  logic                            prod_v_r;
  logic signed [ACC_WIDTH-1:0] acc_r;

  assign head = line_r[0];
  assign acc  = acc_r;

  // shift line, loading enters at the tail, scanning rotates head to tail
  always_ff @(posedge clk) begin
    if (load_en) begin
      for (int i = 0; i < MAX_SIZE - 1; i++) line_r[i] <= line_r[i+1];
      line_r[MAX_SIZE-1] <= load_value;
    end else if (ctl.shift) begin
      for (int i = 0; i < MAX_SIZE - 1; i++) line_r[i] <= line_r[i+1];
      line_r[MAX_SIZE-1] <= line_r[0];
    end
  end

  // registered product then accumulate
  always_ff @(posedge clk) begin
    prod_r   <= line_r[0] * probe;
    prod_v_r <= ctl.accum;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_WIDTH'(prod_r);
    end
  end
endmodule
`default_nettype wire
